### rtl/gtg_pkg.sv
// gtg_pkg: shared types, constants and the cordic angle table
// used by every module of the go-to-goal controller
`timescale 1ns / 1ps

package gtg_pkg;

  localparam int ACT_BITS = 2;
  localparam logic [1:0] ACT_POSE  = 2'd0;
  localparam logic [1:0] ACT_ENTRY = 2'd1;
  localparam logic [1:0] ACT_EMPTY = 2'd2;
  localparam logic [1:0] ACT_TICK  = 2'd3;

  localparam int CFG_IDX_BITS = 2;
  localparam logic [1:0] REG_TOL     = 2'd0;
  localparam logic [1:0] REG_LGAIN   = 2'd1;
  localparam logic [1:0] REG_AGAIN   = 2'd2;
  localparam logic [1:0] REG_CLOSEST = 2'd3;
  localparam int CFG_DATA_BITS = 16;

  localparam int OUT_ID_BITS = 8;
  localparam int GUARD = 14;
  localparam int CW = 36;   // cordic x/y width
  localparam int ZW = 28;   // cordic angle width
  localparam logic signed [ZW-1:0] HALF_PI_Z = 28'sd26353589;
  localparam logic [19:0] INV_K_Q20 = 20'd636751;
  localparam logic signed [17:0] PI_Q13 = 18'sd25736;
  localparam logic signed [17:0] TWO_PI_Q13 = 18'sd51472;

  typedef struct packed {
    logic start;      // begin a tick computation
  } gtg_cmd_t;

  typedef struct packed {
    logic zero_vec;   // dx and dy both zero
    logic done;       // last cordic step taken
  } gtg_sts_t;

  function automatic logic signed [ZW-1:0] atan_z(input logic [4:0] i);
    case (i)
      5'd0: atan_z = 28'sd13176795;
      5'd1: atan_z = 28'sd7778716;
      5'd2: atan_z = 28'sd4110060;
      5'd3: atan_z = 28'sd2086331;
      5'd4: atan_z = 28'sd1047214;
      5'd5: atan_z = 28'sd524117;
      5'd6: atan_z = 28'sd262123;
      5'd7: atan_z = 28'sd131069;
      5'd8: atan_z = 28'sd65536;
      5'd9: atan_z = 28'sd32768;
      5'd10: atan_z = 28'sd16384;
      5'd11: atan_z = 28'sd8192;
      5'd12: atan_z = 28'sd4096;
      5'd13: atan_z = 28'sd2048;
      5'd14: atan_z = 28'sd1024;
      5'd15: atan_z = 28'sd512;
      5'd16: atan_z = 28'sd256;
      5'd17: atan_z = 28'sd128;
      5'd18: atan_z = 28'sd64;
      5'd19: atan_z = 28'sd32;
      5'd20: atan_z = 28'sd16;
      5'd21: atan_z = 28'sd8;
      5'd22: atan_z = 28'sd4;
      5'd23: atan_z = 28'sd2;
      default: atan_z = '0;
    endcase
  endfunction

endpackage

### rtl/gtg_if.sv
// gtg_if: valid/ready channel interfaces for input, result and config
// depends on no other file of the project
`timescale 1ns / 1ps

interface gtg_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] heading;
  logic [7:0]        entry_id;
  logic              entry_first;
  logic              entry_last;
  modport source (output valid, action, pos_x, pos_y, heading, entry_id, entry_first,
                  entry_last, input ready);
  modport sink (input valid, action, pos_x, pos_y, heading, entry_id, entry_first,
                entry_last, output ready);
endinterface

interface gtg_out_if;
  logic              valid;
  logic              ready;
  logic signed [23:0] linear_cmd;
  logic signed [23:0] angular_cmd;
  logic              catch_request;
  logic [7:0]        catch_id;
  modport source (output valid, linear_cmd, angular_cmd, catch_request, catch_id,
                  input ready);
  modport sink (input valid, linear_cmd, angular_cmd, catch_request, catch_id,
                output ready);
endinterface

interface gtg_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/go_to_goal_p_controller.sv
// go_to_goal_p_controller: top level of the proportional go-to-goal block
// depends on gtg_pkg, gtg_if, gtg_ctrl, gtg_dp, gtg_cordic
//
// channel  dir  handshake     payload
// in_      in   valid/ready   action, pos_x, pos_y, heading, entry_id, first, last
// out_     out  valid/ready   linear_cmd, angular_cmd, catch_request, catch_id
// cfg_     in   valid/ready   index, data
//
// pose, entry and empty items are taken whenever input ready is high
// a tick with pose and goal valid runs the one-step-per-cycle cordic, then the
// multiply and finish stages, then holds until the result is taken
// reset clears pose, goal and selection state and loads register defaults
// input ready stays low while a tick is in work or its result waits
`timescale 1ns / 1ps

module go_to_goal_p_controller #(
  parameter int ID_BITS = 8,
  parameter int CORDIC_ITERS = 16
) (
  input logic clk,
  input logic rst_n,
  gtg_in_if.sink    in_ch,
  gtg_out_if.source out_ch,
  gtg_cfg_if.sink   cfg_ch
);
  import gtg_pkg::*;

  logic [14:0] tol_r;
  logic [15:0] lgain_r, again_r;
  logic closest_r;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= 15'd102; lgain_r <= 16'd4096; again_r <= 16'd4096; closest_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_TOL: tol_r <= cfg_ch.data[14:0];
        REG_LGAIN: lgain_r <= cfg_ch.data;
        REG_AGAIN: again_r <= cfg_ch.data;
        REG_CLOSEST: closest_r <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  gtg_cmd_t cmd;
  gtg_sts_t sts;
  logic busy, mul_en, fin_en, can_tick, in_fire, tick_go;

  assign in_ch.ready = !busy;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign tick_go = in_fire && (in_ch.action == ACT_TICK) && can_tick;

  gtg_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .tick_go(tick_go), .sts(sts),
    .out_taken(out_ch.ready), .cmd(cmd), .busy(busy), .mul_en(mul_en),
    .fin_en(fin_en), .out_valid(out_ch.valid)
  );

  gtg_dp #(.ID_BITS(ID_BITS), .CORDIC_ITERS(CORDIC_ITERS)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .action(in_ch.action),
    .pos_x(in_ch.pos_x), .pos_y(in_ch.pos_y), .heading(in_ch.heading),
    .entry_id(ID_BITS'(in_ch.entry_id)), .entry_first(in_ch.entry_first),
    .entry_last(in_ch.entry_last), .tol(tol_r), .lgain(lgain_r),
    .again(again_r), .closest(closest_r), .cmd(cmd), .mul_en(mul_en),
    .fin_en(fin_en), .sts(sts), .can_tick(can_tick),
    .lin_o(out_ch.linear_cmd), .ang_o(out_ch.angular_cmd),
    .req_o(out_ch.catch_request), .cid_o(out_ch.catch_id)
  );

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready) else $error("input accepted during result");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> busy) else $error("tick did not start sequencer");
  a_catch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.catch_request) |->
      (out_ch.linear_cmd == 24'sd0 && out_ch.angular_cmd == 24'sd0))
    else $error("catch with nonzero command");
endmodule

### rtl/gtg_cordic.sv
// gtg_cordic: iterative vectoring cordic, one micro-rotation per cycle
// depends on gtg_pkg
`timescale 1ns / 1ps

module gtg_cordic #(
  parameter int ITERS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  gtg_pkg::gtg_cmd_t            cmd,
  input  logic signed [16:0]           dx,
  input  logic signed [16:0]           dy,
  output gtg_pkg::gtg_sts_t            sts,
  output logic signed [gtg_pkg::CW-1:0] x_out,
  output logic signed [gtg_pkg::ZW-1:0] z_out
);
  import gtg_pkg::*;

  localparam int IB = $clog2(ITERS + 1);

  logic signed [CW-1:0] x_r, y_r, x_nxt, y_nxt, x0, y0, xs, ys;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic [IB-1:0] i_r, i_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt, zero_r, zero_nxt;

  assign x0 = CW'(dx) <<< GUARD;
  assign y0 = CW'(dy) <<< GUARD;
  assign xs = x_r >>> i_r;
  assign ys = y_r >>> i_r;

  always_comb begin
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r; i_nxt = i_r;
    busy_nxt = busy_r; done_nxt = 1'b0; zero_nxt = zero_r;
    if (cmd.start) begin
      zero_nxt = (dx == '0) && (dy == '0);
      if (!y0[CW-1]) begin
        x_nxt = y0; y_nxt = -x0; z_nxt = HALF_PI_Z;
      end else begin
        x_nxt = -y0; y_nxt = x0; z_nxt = -HALF_PI_Z;
      end
      i_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (y_r > 0) begin
        x_nxt = x_r + ys; y_nxt = y_r - xs; z_nxt = z_r + atan_z(5'(i_r));
      end else begin
        x_nxt = x_r - ys; y_nxt = y_r + xs; z_nxt = z_r - atan_z(5'(i_r));
      end
      i_nxt = i_r + 1'b1;
      if (i_r == IB'(ITERS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt; i_r <= i_nxt; zero_r <= zero_nxt;
  end

  assign sts.done = done_r;
  assign sts.zero_vec = zero_r;
  assign x_out = x_r;
  assign z_out = z_r;
endmodule

### rtl/gtg_ctrl.sv
// gtg_ctrl: sequencer for the tick computation
// drives the cordic and the output stage, depends on gtg_pkg
`timescale 1ns / 1ps

module gtg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              tick_go,
  input  gtg_pkg::gtg_sts_t sts,
  input  logic              out_taken,
  output gtg_pkg::gtg_cmd_t cmd,
  output logic              busy,
  output logic              mul_en,
  output logic              fin_en,
  output logic              out_valid
);
  import gtg_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_RUN, S_MUL, S_FIN, S_OUT} state_t;
  state_t state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: if (tick_go) state_r <= S_RUN;
        S_RUN: if (sts.done) state_r <= S_MUL;
        S_MUL: state_r <= S_FIN;
        S_FIN: state_r <= S_OUT;
        S_OUT: if (out_taken) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign cmd.start = (state_r == S_IDLE) && tick_go;
  assign busy = (state_r != S_IDLE);
  assign mul_en = (state_r == S_MUL);
  assign fin_en = (state_r == S_FIN);
  assign out_valid = (state_r == S_OUT);
endmodule

### rtl/gtg_dp.sv
// gtg_dp: pose, goal and selection registers plus command arithmetic
// instantiates gtg_cordic, depends on gtg_pkg
`timescale 1ns / 1ps

module gtg_dp #(
  parameter int ID_BITS = 8,
  parameter int CORDIC_ITERS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic [1:0]        action,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [15:0] heading,
  input  logic [ID_BITS-1:0] entry_id,
  input  logic              entry_first,
  input  logic              entry_last,
  input  logic [14:0]       tol,
  input  logic [15:0]       lgain,
  input  logic [15:0]       again,
  input  logic              closest,
  input  gtg_pkg::gtg_cmd_t cmd,
  input  logic              mul_en,
  input  logic              fin_en,
  output gtg_pkg::gtg_sts_t sts,
  output logic              can_tick,
  output logic signed [23:0] lin_o,
  output logic signed [23:0] ang_o,
  output logic              req_o,
  output logic [7:0]        cid_o
);
  import gtg_pkg::*;

  logic signed [15:0] px_r, py_r, ph_r, gx_r, gy_r, bx_r, by_r;
  logic [ID_BITS-1:0] gid_r, bid_r;
  logic [33:0] bd_r;
  logic pv_r, gv_r;

  logic signed [16:0] ex, ey;
  logic signed [33:0] ex2, ey2;
  logic [33:0] d2;
  logic signed [CW-1:0] cx;
  logic signed [ZW-1:0] cz;

  assign ex = 17'(pos_x) - 17'(px_r);
  assign ey = 17'(pos_y) - 17'(py_r);
  assign ex2 = 34'(ex) * 34'(ex);
  assign ey2 = 34'(ey) * 34'(ey);
  assign d2 = $unsigned(ex2) + $unsigned(ey2);
  assign can_tick = pv_r && gv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r <= '0; py_r <= '0; ph_r <= '0; pv_r <= 1'b0;
      gx_r <= '0; gy_r <= '0; gid_r <= '0; gv_r <= 1'b0;
      bx_r <= '0; by_r <= '0; bid_r <= '0; bd_r <= '0;
    end else if (in_fire) begin
      case (action)
        ACT_POSE: begin
          px_r <= pos_x; py_r <= pos_y; ph_r <= heading; pv_r <= 1'b1;
        end
        ACT_ENTRY: begin
          if (entry_first || (closest && d2 < bd_r)) begin
            bx_r <= pos_x; by_r <= pos_y; bid_r <= entry_id; bd_r <= d2;
          end
          if (entry_last) begin
            if (entry_first || (closest && d2 < bd_r)) begin
              gx_r <= pos_x; gy_r <= pos_y; gid_r <= entry_id;
            end else begin
              gx_r <= bx_r; gy_r <= by_r; gid_r <= bid_r;
            end
            gv_r <= 1'b1;
          end
        end
        ACT_EMPTY: gv_r <= 1'b0;
        default: ;
      endcase
    end
  end

  gtg_cordic #(.ITERS(CORDIC_ITERS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .cmd(cmd),
    .dx(17'(gx_r) - 17'(px_r)),
    .dy(17'(gy_r) - 17'(py_r)),
    .sts(sts), .x_out(cx), .z_out(cz)
  );

  // stage 1: magnitude scale and bearing round
  logic signed [CW+21-1:0] mag_p;
  logic signed [17:0] dist_r, err_r;
  logic signed [ZW-1:0] brg_w;
  logic signed [17:0] brg, e0, e1;

  assign mag_p = cx * $signed({1'b0, INV_K_Q20});
  assign brg_w = (cz + ZW'(1024)) >>> 11;
  assign brg = sts.zero_vec ? 18'sd0 : 18'(brg_w);
  assign e0 = brg - 18'(ph_r);
  always_comb begin
    e1 = e0;
    if (e0 > PI_Q13) e1 = e0 - TWO_PI_Q13;
    else if (e0 <= -PI_Q13) e1 = e0 + TWO_PI_Q13;
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      dist_r <= sts.zero_vec ? 18'sd0 :
                18'((mag_p + (57'sd1 <<< (19 + GUARD))) >>> (20 + GUARD));
      err_r <= e1;
    end
  end

  // stage 2: gains, rounding, saturation
  logic signed [35:0] lp, ap, lr, ar;
  logic catch_w;
  assign catch_w = dist_r < $signed({3'b0, tol});
  assign lp = dist_r * $signed({1'b0, lgain});
  assign ap = err_r * $signed({1'b0, again});
  assign lr = (lp + 36'sd2048) >>> 12;
  assign ar = (ap + 36'sd2048) >>> 12;

  function automatic logic signed [23:0] sat(input logic signed [35:0] v);
    if (v > 36'sd8388607) sat = 24'sh7fffff;
    else if (v < -36'sd8388608) sat = 24'sh800000;
    else sat = 24'(v);
  endfunction

  always_ff @(posedge clk) begin
    if (fin_en) begin
      req_o <= catch_w;
      cid_o <= catch_w ? 8'(gid_r) : 8'd0;
      lin_o <= catch_w ? 24'sd0 : sat(lr);
      ang_o <= catch_w ? 24'sd0 : sat(ar);
    end
  end
endmodule
